FILE: hdl/aet_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package aet_pkg;

   localparam int MAX_EDGES   = 32;
   localparam int IDX_W       = $clog2(MAX_EDGES);
   localparam int CNT_W       = IDX_W + 1;
   localparam int X_FRAC_BITS = 16;
   localparam int X_W         = 32;
   localparam int ROW_W       = 16;
   localparam int STEP_W      = 10;
   localparam int SLOT_W      = 5;
   localparam int PROD_W      = X_W + STEP_W + 1;

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_SCAN  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   typedef struct packed {
      logic                    valid;
      logic                    kill;
      logic signed [ROW_W-1:0] upper;
      logic signed [X_W-1:0]   x;
      logic signed [X_W-1:0]   slope;
   } entry_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_MARK,
      CELL_SORT,
      CELL_PRUNE,
      CELL_SHIFT,
      CELL_CLEAR
   } cell_op_type;

   typedef struct packed {
      cell_op_type             op;
      logic                    phase;
      logic signed [ROW_W-1:0] row;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MARK,
      ST_SORT,
      ST_PRUNE,
      ST_EMPTY,
      ST_EMIT_A,
      ST_EMIT_B
   } state_type;

   // a orders after b: killed edges go last, then larger x
   function automatic logic entry_gt(input entry_type a, input entry_type b);
      entry_gt = a.valid && b.valid &&
                 ((a.kill && !b.kill) || ((a.kill == b.kill) && (a.x > b.x)));
   endfunction

endpackage

`default_nettype wire

FILE: hdl/scanline_active_edge_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Active edge table for scanline polygon fill. Load transfers append an edge to a
// 32-entry pending table (loads past capacity are dropped); a clear empties both
// tables. A scanline transfer for row y moves pending edges starting on y into
// the active chain, sorts it stably by x with edges ending on y pushed to the tail
// and dropped, then sends one result transfer per active edge in x order (or one
// no_edges result) and advances every x by row_step * slope with saturation.
// Load, clear and idle commands complete in the idle state. A scanline transfer runs a
// pending scan, a mark step, the sort phases of the cell chain and a prune, then takes
// each chain position through emit and advance with one shared multiplier, waiting while
// the result side stalls. req_ready is high only between items.
module scanline_active_edge_table_unit (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire        [1:0]                   req_command,
   input  wire signed [15:0]                  req_edge_y_low,
   input  wire signed [15:0]                  req_edge_y_high,
   input  wire signed [31:0]                  req_edge_x_start,
   input  wire signed [31:0]                  req_edge_x_slope,
   input  wire signed [15:0]                  req_scan_row,
   input  wire        [9:0]                   req_row_step,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic signed [31:0]                 rsp_x_crossing,
   output logic       [4:0]                   rsp_slot_index,
   output logic                               rsp_no_edges,
   output logic                               rsp_last_of_run
);

   localparam int N = aet_pkg::MAX_EDGES;
   localparam int IW = aet_pkg::IDX_W;
   localparam int CW = aet_pkg::CNT_W;

   // pending table, entry contents valid only where live
   logic signed [15:0] pend_ylow  [N];
   logic signed [15:0] pend_yhigh [N];
   logic signed [31:0] pend_x     [N];
   logic signed [31:0] pend_slope [N];
   logic [N-1:0]       pend_live_ff, pend_live_in;
   logic [CW-1:0]      pend_cnt_ff, pend_cnt_in;
   logic               pend_wr;

   // pending entry at the scan index, registered ahead from the next scan index
   logic signed [15:0] rd_ylow_ff;
   logic signed [15:0] rd_yhigh_ff;
   logic signed [31:0] rd_x_ff;
   logic signed [31:0] rd_slope_ff;

   logic [CW-1:0]      act_cnt_ff, act_cnt_in;
   aet_pkg::state_type state_ff, state_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic signed [15:0] row_ff, row_in;
   logic [9:0]         step_ff, step_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_x_ff, rsp_x_in;
   logic [4:0]         rsp_slot_ff, rsp_slot_in;
   logic               rsp_empty_ff, rsp_empty_in;
   logic               rsp_last_ff, rsp_last_in;

   aet_pkg::cell_ctl_type ctl;
   aet_pkg::entry_type    cells    [N];
   aet_pkg::entry_type    left_e   [N];
   aet_pkg::entry_type    right_e  [N];
   aet_pkg::entry_type    load_e;
   aet_pkg::entry_type    wrap_e;
   aet_pkg::entry_type    none_e;
   logic [N-1:0]          survive;
   logic [CW-1:0]         survive_cnt;
   logic                  adv_capture;
   logic signed [31:0]    adv_x;
   logic                  rsp_free;
   logic                  accept;
   logic                  scan_hit;

   assign accept   = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // edge entering the active chain during the pending scan
   always_comb begin
      load_e.valid = 1'b1;
      load_e.kill  = 1'b0;
      load_e.upper = rd_yhigh_ff;
      load_e.x     = rd_x_ff;
      load_e.slope = rd_slope_ff;
      none_e       = '0;
      wrap_e.valid = cells[0].valid;
      wrap_e.kill  = 1'b0;
      wrap_e.upper = cells[0].upper;
      wrap_e.x     = adv_x;
      wrap_e.slope = cells[0].slope;
   end

   assign scan_hit = ({1'b0, idx_ff} < pend_cnt_ff) && pend_live_ff[idx_ff] &&
                     (rd_ylow_ff == row_ff) && (act_cnt_ff < CW'(N));

   always_comb begin
      for (int i = 0; i < N; i++) begin
         survive[i] = cells[i].valid && !cells[i].kill;
      end
      survive_cnt = CW'($countones(survive));
   end

   // neighbor wiring; the tail takes the advanced head while rotating
   always_comb begin
      for (int i = 0; i < N; i++) begin
         left_e[i]  = (i == 0) ? none_e : cells[(i == 0) ? 0 : i-1];
         right_e[i] = (i == N-1) ? ((ctl.op == aet_pkg::CELL_SHIFT) ? wrap_e : none_e)
                                 : cells[(i == N-1) ? 0 : i+1];
      end
   end

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_cell
         aet_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .load_sel    (act_cnt_ff == CW'(g)),
            .load_entry  (load_e),
            .pos_odd     (1'(g % 2)),
            .left_entry  (left_e[g]),
            .right_entry (right_e[g]),
            .cell_entry  (cells[g])
         );
      end
   endgenerate

   aet_advance u_advance (
      .clock   (clock),
      .capture (adv_capture),
      .step    (step_ff),
      .x       (cells[0].x),
      .slope   (cells[0].slope),
      .x_next  (adv_x)
   );

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      row_in       = row_ff;
      step_in      = step_ff;
      pend_live_in = pend_live_ff;
      pend_cnt_in  = pend_cnt_ff;
      pend_wr      = 1'b0;
      act_cnt_in   = act_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_x_in     = rsp_x_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_last_in  = rsp_last_ff;
      adv_capture  = 1'b0;
      req_ready    = 1'b0;
      ctl.op       = aet_pkg::CELL_HOLD;
      ctl.phase    = idx_ff[0];
      ctl.row      = row_ff;

      unique case (state_ff)
         aet_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               case (req_command)
                  aet_pkg::CMD_LOAD: begin
                     if (pend_cnt_ff < CW'(N)) begin
                        pend_wr = 1'b1;
                        pend_live_in[pend_cnt_ff[IW-1:0]] = 1'b1;
                        pend_cnt_in = pend_cnt_ff + 1'b1;
                     end
                  end
                  aet_pkg::CMD_SCAN: begin
                     row_in   = req_scan_row;
                     step_in  = req_row_step;
                     idx_in   = '0;
                     state_in = aet_pkg::ST_SCAN;
                  end
                  aet_pkg::CMD_CLEAR: begin
                     pend_live_in = '0;
                     pend_cnt_in  = '0;
                     act_cnt_in   = '0;
                     ctl.op       = aet_pkg::CELL_CLEAR;
                  end
                  default: ;
               endcase
            end
         end
         aet_pkg::ST_SCAN: begin
            if (scan_hit) begin
               ctl.op                = aet_pkg::CELL_LOAD;
               act_cnt_in            = act_cnt_ff + 1'b1;
               pend_live_in[idx_ff]  = 1'b0;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IW'(N-1)) state_in = aet_pkg::ST_MARK;
         end
         aet_pkg::ST_MARK: begin
            ctl.op   = aet_pkg::CELL_MARK;
            idx_in   = '0;
            state_in = aet_pkg::ST_SORT;
         end
         aet_pkg::ST_SORT: begin
            ctl.op = aet_pkg::CELL_SORT;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IW'(N-1)) state_in = aet_pkg::ST_PRUNE;
         end
         aet_pkg::ST_PRUNE: begin
            ctl.op     = aet_pkg::CELL_PRUNE;
            act_cnt_in = survive_cnt;
            idx_in     = '0;
            state_in   = (survive_cnt == '0) ? aet_pkg::ST_EMPTY : aet_pkg::ST_EMIT_A;
         end
         aet_pkg::ST_EMPTY: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = '0;
               rsp_slot_in  = '0;
               rsp_empty_in = 1'b1;
               rsp_last_in  = 1'b1;
               state_in     = aet_pkg::ST_IDLE;
            end
         end
         aet_pkg::ST_EMIT_A: begin
            // head goes out and into the multiplier, positions past the count only rotate
            if ({1'b0, idx_ff} < act_cnt_ff) begin
               if (rsp_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_x_in     = cells[0].x;
                  rsp_slot_in  = 5'(idx_ff);
                  rsp_empty_in = 1'b0;
                  rsp_last_in  = ({1'b0, idx_ff} == act_cnt_ff - 1'b1);
                  adv_capture  = 1'b1;
                  state_in     = aet_pkg::ST_EMIT_B;
               end
            end else begin
               adv_capture = 1'b1;
               state_in    = aet_pkg::ST_EMIT_B;
            end
         end
         aet_pkg::ST_EMIT_B: begin
            ctl.op = aet_pkg::CELL_SHIFT;
            idx_in = idx_ff + 1'b1;
            state_in = (idx_ff == IW'(N-1)) ? aet_pkg::ST_IDLE : aet_pkg::ST_EMIT_A;
         end
         default: state_in = aet_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pend_wr) begin
         pend_ylow[pend_cnt_ff[IW-1:0]]  <= req_edge_y_low;
         pend_yhigh[pend_cnt_ff[IW-1:0]] <= req_edge_y_high;
         pend_x[pend_cnt_ff[IW-1:0]]     <= req_edge_x_start;
         pend_slope[pend_cnt_ff[IW-1:0]] <= req_edge_x_slope;
      end
      // no load is accepted during a scan, so the fetch always sees written data
      rd_ylow_ff  <= pend_ylow[idx_in];
      rd_yhigh_ff <= pend_yhigh[idx_in];
      rd_x_ff     <= pend_x[idx_in];
      rd_slope_ff <= pend_slope[idx_in];
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      row_ff      <= row_in;
      step_ff     <= step_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff     <= aet_pkg::ST_IDLE;
         pend_live_ff <= '0;
         pend_cnt_ff  <= '0;
         act_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_live_ff <= pend_live_in;
         pend_cnt_ff  <= pend_cnt_in;
         act_cnt_ff   <= act_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_x_crossing  = rsp_x_ff;
   assign rsp_slot_index  = rsp_slot_ff;
   assign rsp_no_edges    = rsp_empty_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

`default_nettype wire

FILE: hdl/aet_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module aet_cell (
   input  wire                   clock,
   input  wire                   reset,
   input  aet_pkg::cell_ctl_type ctl,
   input  wire                   load_sel,
   input  aet_pkg::entry_type    load_entry,
   input  wire                   pos_odd,
   input  aet_pkg::entry_type    left_entry,
   input  aet_pkg::entry_type    right_entry,
   output aet_pkg::entry_type    cell_entry
);

   aet_pkg::entry_type ent_ff, ent_in;
   logic pair_lo;

   always_comb begin
      ent_in  = ent_ff;
      pair_lo = (pos_odd == ctl.phase);
      case (ctl.op)
         aet_pkg::CELL_LOAD: begin
            if (load_sel) ent_in = load_entry;
         end
         aet_pkg::CELL_MARK: begin
            ent_in.kill = ent_ff.valid && (ent_ff.upper == ctl.row);
         end
         aet_pkg::CELL_SORT: begin
            // odd-even transposition, strict compare keeps ties in order
            if (pair_lo) begin
               if (aet_pkg::entry_gt(ent_ff, right_entry)) ent_in = right_entry;
            end else begin
               if (aet_pkg::entry_gt(left_entry, ent_ff)) ent_in = left_entry;
            end
         end
         aet_pkg::CELL_PRUNE: begin
            ent_in.valid = ent_ff.valid && !ent_ff.kill;
            ent_in.kill  = 1'b0;
         end
         aet_pkg::CELL_SHIFT: ent_in = right_entry;
         aet_pkg::CELL_CLEAR: begin
            ent_in.valid = 1'b0;
            ent_in.kill  = 1'b0;
         end
         default: ent_in = ent_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff <= '0;
      end else begin
         ent_ff <= ent_in;
      end
   end

   assign cell_entry = ent_ff;

endmodule

`default_nettype wire

FILE: hdl/aet_advance.sv
`timescale 1ns / 1ps
`default_nettype none

module aet_advance (
   input  wire                                  clock,
   input  wire                                  capture,
   input  wire        [aet_pkg::STEP_W-1:0]     step,
   input  wire signed [aet_pkg::X_W-1:0]        x,
   input  wire signed [aet_pkg::X_W-1:0]        slope,
   output logic signed [aet_pkg::X_W-1:0]       x_next
);

   logic signed [aet_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [aet_pkg::X_W-1:0]    x_ff, x_in;
   logic signed [aet_pkg::PROD_W:0]   sum;
   localparam logic signed [aet_pkg::PROD_W:0] X_MAX =
      (aet_pkg::PROD_W+1)'(signed'({1'b0, {(aet_pkg::X_W-1){1'b1}}}));
   localparam logic signed [aet_pkg::PROD_W:0] X_MIN = -X_MAX - 1;

   // integer rows times fixed-point slope keeps the binary point
   always_comb begin
      prod_in = capture ? ($signed({1'b0, step}) * slope) : prod_ff;
      x_in    = capture ? x : x_ff;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      x_ff    <= x_in;
   end

   always_comb begin
      sum = (aet_pkg::PROD_W+1)'(x_ff) + (aet_pkg::PROD_W+1)'(prod_ff);
      if (sum > X_MAX)      x_next = X_MAX[aet_pkg::X_W-1:0];
      else if (sum < X_MIN) x_next = X_MIN[aet_pkg::X_W-1:0];
      else                  x_next = sum[aet_pkg::X_W-1:0];
   end

endmodule

`default_nettype wire
